@@ sv/crrs_pkg.sv @@
package crrs_pkg;

  localparam int QDepth = 16;
  localparam int IdxW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW   = $clog2(QDepth + 1);
  localparam int FifoDepth = 2;

  localparam logic [16:0] ChunkReset = 17'd4096;
  localparam logic [16:0] LimitMax   = 17'd65536;
  localparam logic [16:0] LimitMin   = 17'd1;

  localparam logic [1:0] ActSubmit   = 2'd0;
  localparam logic [1:0] ActIssue    = 2'd1;
  localparam logic [1:0] ActComplete = 2'd2;

  typedef enum logic [1:0] {
    OP_SUBMIT,
    OP_ISSUE,
    OP_COMPLETE,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT   = 3'd0,
    KIND_REJECT   = 3'd1,
    KIND_CMD      = 3'd2,
    KIND_DONE_OK  = 3'd3,
    KIND_DONE_ERR = 3'd4,
    KIND_IDLE     = 3'd5
  } kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_ISSUE
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  tag;
    logic [31:0] buffer;
    logic [31:0] position;
    logic [23:0] size;
    logic        dir;
    logic [16:0] xfer;
    logic        failed;
    logic [7:0]  ecode;
  } item_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] buffer;
    logic [31:0] position;
    logic [23:0] total;
    logic [23:0] done;
    logic        dir;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag;
    logic [31:0] cmd_buffer;
    logic [31:0] cmd_position;
    logic [16:0] cmd_length;
    logic        cmd_write;
    logic [23:0] done_bytes;
    logic [7:0]  done_error;
  } result_t;

  typedef struct packed {
    logic            busy;
    logic [CntW-1:0] count;
  } back_status_t;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] n;
    n = (i == IdxW'(QDepth - 1)) ? '0 : i + 1'b1;
    return n;
  endfunction

endpackage

@@ sv/crrs_front.sv @@
module crrs_front import crrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  req_id_i,
  input  logic [31:0] buffer_address_i,
  input  logic [31:0] position_i,
  input  logic [23:0] request_size_i,
  input  logic        is_write_i,
  input  logic [16:0] xfer_bytes_i,
  input  logic        xfer_failed_i,
  input  logic [7:0]  error_code_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_pop_i
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int FCntW = $clog2(FifoDepth + 1);

  item_t             fifo_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FCntW-1:0]  cnt_q, cnt_d;
  item_t             item_in;
  logic              push, pop;

  always_comb begin
    item_in.tag      = req_id_i;
    item_in.buffer   = buffer_address_i;
    item_in.position = position_i;
    item_in.size     = request_size_i;
    item_in.dir      = is_write_i;
    item_in.xfer     = xfer_bytes_i;
    item_in.failed   = xfer_failed_i;
    item_in.ecode    = error_code_i;
    case (action_i)
      ActSubmit:   item_in.op = OP_SUBMIT;
      ActIssue:    item_in.op = OP_ISSUE;
      ActComplete: item_in.op = OP_COMPLETE;
      default:     item_in.op = OP_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != FCntW'(FifoDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ sv/crrs_back.sv @@
module crrs_back import crrs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [16:0]  limit_i,
  input  logic         item_valid_i,
  input  item_t        item_i,
  output logic         item_pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output result_t      result_o,
  output back_status_t status_o
);

  entry_t          mem_q [QDepth];
  entry_t          rdata_q;
  logic            rd_en;
  logic            mem_we;
  entry_t          mem_wdata;

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            busy_valid_q, busy_valid_d;
  entry_t          busy_q, busy_d;
  logic [16:0]     busy_len_q, busy_len_d;
  logic            out_valid_q, out_valid_d;
  result_t         res_q, res_d;

  logic            out_free;
  logic            full;
  logic [24:0]     nd_sum;
  logic [23:0]     nd;
  logic [16:0]     cmd_len;

  assign out_free = !out_valid_q || out_ready_i;
  assign full     = ({1'b0, count_q} + (CntW + 1)'(busy_valid_q)) >= (CntW + 1)'(QDepth);
  assign nd_sum   = {1'b0, busy_q.done} + 25'(item_i.xfer);
  assign nd       = nd_sum[24] ? '1 : nd_sum[23:0];
  assign cmd_len  = (rdata_q.total > 24'(limit_i)) ? limit_i : rdata_q.total[16:0];

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    busy_valid_d = busy_valid_q;
    busy_d       = busy_q;
    busy_len_d   = busy_len_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_d        = res_q;
    item_pop_o   = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = busy_q;
    case (state_q)
      BK_IDLE: begin
        if (item_valid_i && out_free) begin
          item_pop_o  = 1'b1;
          out_valid_d = 1'b1;
          res_d       = '0;
          res_d.kind  = KIND_IDLE;
          case (item_i.op)
            OP_SUBMIT: begin
              res_d.tag = item_i.tag;
              if (item_i.size == '0 || full) begin
                res_d.kind = KIND_REJECT;
              end else begin
                mem_we             = 1'b1;
                mem_wdata.tag      = item_i.tag;
                mem_wdata.buffer   = item_i.buffer;
                mem_wdata.position = item_i.position;
                mem_wdata.total    = item_i.size;
                mem_wdata.done     = '0;
                mem_wdata.dir      = item_i.dir;
                tail_d             = next_slot(tail_q);
                count_d            = count_q + 1'b1;
                res_d.kind         = KIND_ACCEPT;
              end
            end
            OP_ISSUE: begin
              if (busy_valid_q) begin
                res_d.kind = KIND_REJECT;
                res_d.tag  = busy_q.tag;
              end else if (count_q != '0) begin
                out_valid_d = out_valid_q && !out_ready_i;
                res_d       = res_q;
                rd_en       = 1'b1;
                head_d      = next_slot(head_q);
                count_d     = count_q - 1'b1;
                state_d     = BK_ISSUE;
              end
            end
            OP_COMPLETE: begin
              if (busy_valid_q) begin
                res_d.tag    = busy_q.tag;
                busy_valid_d = 1'b0;
                if (item_i.failed) begin
                  res_d.kind       = KIND_DONE_ERR;
                  res_d.done_bytes = busy_q.done;
                  res_d.done_error = item_i.ecode;
                end else if (item_i.xfer == '0) begin
                  res_d.kind       = KIND_DONE_OK;
                  res_d.done_bytes = busy_q.done;
                end else begin
                  busy_d.done = nd;
                  if (item_i.xfer < busy_len_q || nd >= busy_q.total) begin
                    res_d.kind       = KIND_DONE_OK;
                    res_d.done_bytes = nd;
                  end else begin
                    mem_we         = 1'b1;
                    mem_wdata.done = nd;
                    tail_d         = next_slot(tail_q);
                    count_d        = count_q + 1'b1;
                    res_d.kind     = KIND_ACCEPT;
                  end
                end
              end
            end
            default: begin
              res_d.kind = KIND_IDLE;
            end
          endcase
        end
      end
      BK_ISSUE: begin
        if (out_free) begin
          busy_d             = rdata_q;
          busy_len_d         = cmd_len;
          busy_valid_d       = 1'b1;
          out_valid_d        = 1'b1;
          res_d              = '0;
          res_d.kind         = KIND_CMD;
          res_d.tag          = rdata_q.tag;
          res_d.cmd_buffer   = rdata_q.buffer + 32'(rdata_q.done);
          res_d.cmd_position = rdata_q.position + 32'(rdata_q.done);
          res_d.cmd_length   = cmd_len;
          res_d.cmd_write    = rdata_q.dir;
          state_d            = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      busy_valid_q <= 1'b0;
      busy_q       <= '0;
      busy_len_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      busy_valid_q <= busy_valid_d;
      busy_q       <= busy_d;
      busy_len_q   <= busy_len_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_o       = res_q;
  assign status_o.busy  = busy_valid_q;
  assign status_o.count = count_q;

endmodule

@@ sv/chunked_round_robin_io_scheduler.sv @@
// Flow: an item is held in the front FIFO until the back end pops it and registers its
// result; an issue that pops a request goes through BK_IDLE and then BK_ISSUE.
// Throughput: one item per cycle while the output is not stalled; an issue that pops a
// request also needs BK_ISSUE, for the registered read of the request queue memory.
// Reset: asynchronous, active low; clears queue pointers, count, the in-flight request
// and both handshake stages, and sets chunk_limit to 4096. Queue storage is not cleared.
module chunked_round_robin_io_scheduler import crrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  req_id_i,
  input  logic [31:0] buffer_address_i,
  input  logic [31:0] position_i,
  input  logic [23:0] request_size_i,
  input  logic        is_write_i,
  input  logic [16:0] xfer_bytes_i,
  input  logic        xfer_failed_i,
  input  logic [7:0]  error_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_req_id_o,
  output logic [31:0] cmd_buffer_o,
  output logic [31:0] cmd_position_o,
  output logic [16:0] cmd_length_o,
  output logic        cmd_write_o,
  output logic [23:0] done_bytes_o,
  output logic [7:0]  done_error_o
);

  logic [16:0]  chunk_limit_q;
  logic [16:0]  limit;
  logic         item_valid;
  item_t        item;
  logic         item_pop;
  result_t      result;
  back_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= ChunkReset;
    end else if (cfg_we_i) begin
      chunk_limit_q <= cfg_data_i;
    end
  end

  assign limit = (chunk_limit_q == '0)      ? LimitMin :
                 (chunk_limit_q > LimitMax) ? LimitMax : chunk_limit_q;

  crrs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .req_id_i         (req_id_i),
    .buffer_address_i (buffer_address_i),
    .position_i       (position_i),
    .request_size_i   (request_size_i),
    .is_write_i       (is_write_i),
    .xfer_bytes_i     (xfer_bytes_i),
    .xfer_failed_i    (xfer_failed_i),
    .error_code_i     (error_code_i),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_pop_i       (item_pop)
  );

  crrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result),
    .status_o     (status)
  );

  assign kind_o         = result.kind;
  assign out_req_id_o   = result.tag;
  assign cmd_buffer_o   = result.cmd_buffer;
  assign cmd_position_o = result.cmd_position;
  assign cmd_length_o   = result.cmd_length;
  assign cmd_write_o    = result.cmd_write;
  assign done_bytes_o   = result.done_bytes;
  assign done_error_o   = result.done_error;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, status.count} + (CntW + 1)'(status.busy)) <= (CntW + 1)'(QDepth))
    else $error("request queue holds more than its depth");

  a_cmd_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_CMD) |-> (cmd_length_o != '0))
    else $error("command issued with zero length");

  a_busy_with_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.busy) |-> (out_valid_o && kind_o == KIND_CMD))
    else $error("request in flight without a command result");
`endif

endmodule
